// ----- sv/alpf_pkg.sv -----
// ----------------------------------------------------------------------------
// Adaptive low-pass filter package
// Shared types and constants for the adaptive first-order low-pass filter.
// ----------------------------------------------------------------------------
package alpf_pkg;

	localparam int COEF_W = 8;
	localparam int COUNT_W = 8;
	localparam int THR_W = 24;
	localparam int CFG_IDX_W = 2;

	// Coefficient is in 1/256 units, so the product is shifted by 8 after rounding.
	localparam int COEF_FRAC = 8;
	localparam int ROUND_HALF = 128;

	localparam logic [COUNT_W-1:0] BIG_INC = 8'd10;
	localparam logic [COUNT_W-1:0] SMALL_INC = 8'd1;

	localparam logic [COEF_W-1:0] MAX_COEF_RST = 8'd150;
	localparam logic [COEF_W-1:0] COEF_STEP_RST = 8'd15;
	localparam logic [COUNT_W-1:0] SETTLE_LIMIT_RST = 8'd30;
	localparam logic [THR_W-1:0] BIG_THR_RST = 24'd200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_COEF = 2'd0,
		REG_COEF_STEP = 2'd1,
		REG_SETTLE_LIMIT = 2'd2,
		REG_BIG_THR = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [COEF_W-1:0] max_coef;
		logic [COEF_W-1:0] coef_step;
		logic [COUNT_W-1:0] settle_limit;
		logic [THR_W-1:0] big_thr;
	} cfg_t;

	typedef struct packed {
		logic sign_flip;
		logic coef_raise;
	} stat_t;

endpackage

// ----- sv/alpf_in_if.sv -----
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one signed sample per beat.
// ----------------------------------------------------------------------------
interface alpf_in_if #(
	parameter int W = 24
);
	logic valid;
	logic ready;
	logic signed [W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ----- sv/alpf_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the filter output and coefficient per beat.
// ----------------------------------------------------------------------------
interface alpf_out_if #(
	parameter int W = 24
);
	logic valid;
	logic ready;
	logic signed [W-1:0] filtered;
	logic [7:0] coef_now;

	modport source (output valid, output filtered, output coef_now, input ready);
	modport sink (input valid, input filtered, input coef_now, output ready);
endinterface

// ----- sv/alpf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file holding the filter tuning values.
// ----------------------------------------------------------------------------
module alpf_cfg_regs import alpf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;
	cfg_reg_t idx;

	assign idx = cfg_reg_t'(cfg_index);
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_coef <= MAX_COEF_RST;
			cfg_q.coef_step <= COEF_STEP_RST;
			cfg_q.settle_limit <= SETTLE_LIMIT_RST;
			cfg_q.big_thr <= BIG_THR_RST;
		end else if (cfg_we) begin
			unique case (idx)
				REG_MAX_COEF: cfg_q.max_coef <= cfg_wdata[COEF_W-1:0];
				REG_COEF_STEP: cfg_q.coef_step <= cfg_wdata[COEF_W-1:0];
				REG_SETTLE_LIMIT: cfg_q.settle_limit <= cfg_wdata[COUNT_W-1:0];
				REG_BIG_THR: cfg_q.big_thr <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

// ----- sv/alpf_adapt.sv -----
// ----------------------------------------------------------------------------
// Coefficient adaptation
// Next settle count and smoothing coefficient from the sign history of delta.
// ----------------------------------------------------------------------------
module alpf_adapt import alpf_pkg::*; (
	input  cfg_t               cfg,
	input  logic               same_sign,
	input  logic               mag_big,
	input  logic [COUNT_W-1:0] count,
	input  logic [COEF_W-1:0]  coef,
	output logic [COUNT_W-1:0] count_next,
	output logic [COEF_W-1:0]  coef_next,
	output logic               coef_raise
);

	logic [COUNT_W:0] count_sum;
	logic [COEF_W:0]  coef_sum;

	assign count_sum = {1'b0, count} + {1'b0, (mag_big ? BIG_INC : SMALL_INC)};
	assign coef_sum = {1'b0, coef} + {1'b0, cfg.coef_step};

	always_comb begin
		count_next = count;
		coef_next = coef;
		coef_raise = 1'b0;
		priority if (!same_sign) begin
			count_next = '0;
			coef_next = '0;
		end else if (count < cfg.settle_limit) begin
			// The count saturates at its top value.
			count_next = count_sum[COUNT_W] ? {COUNT_W{1'b1}} : count_sum[COUNT_W-1:0];
		end else begin
			count_next = '0;
			coef_raise = 1'b1;
			coef_next = (coef_sum < {1'b0, cfg.max_coef}) ? coef_sum[COEF_W-1:0]
				: cfg.max_coef;
		end
	end

endmodule

// ----- sv/alpf_core.sv -----
// ----------------------------------------------------------------------------
// Filter core
// Filter state and the per-sample update: delta, adaptation, scaled step.
// ----------------------------------------------------------------------------
module alpf_core import alpf_pkg::*; #(
	parameter int W = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic signed [W-1:0] sample,
	input  cfg_t                cfg,
	output logic signed [W-1:0] filtered,
	output logic [COEF_W-1:0]   coef_now,
	output logic signed [W-1:0] filter_state,
	output stat_t               stat
);

	localparam int MAG_W = W + 1;
	localparam int PROD_W = MAG_W + COEF_W;
	localparam int CMP_W = (MAG_W > THR_W) ? MAG_W : THR_W;

	logic signed [W-1:0]  filter_q;
	logic                 last_neg_q;
	logic [COEF_W-1:0]    coef_q;
	logic [COUNT_W-1:0]   count_q;

	logic signed [W:0]    delta;
	logic                 neg;
	logic [MAG_W-1:0]     mag;
	logic                 mag_big;
	logic [COUNT_W-1:0]   count_next;
	logic [COEF_W-1:0]    coef_next;
	logic                 coef_raise;
	logic [PROD_W-1:0]    prod;
	logic [PROD_W-1:0]    prod_rnd;
	logic [MAG_W-1:0]     step;
	logic signed [W+1:0]  filt_ext;
	logic signed [W+1:0]  filt_next;

	assign delta = {sample[W-1], sample} - {filter_q[W-1], filter_q};
	assign neg = delta[W];
	assign mag = neg ? MAG_W'(-delta) : MAG_W'(delta);
	assign mag_big = CMP_W'(mag) > CMP_W'(cfg.big_thr);

	alpf_adapt u_adapt (
		.cfg        (cfg),
		.same_sign  (neg == last_neg_q),
		.mag_big    (mag_big),
		.count      (count_q),
		.coef       (coef_q),
		.count_next (count_next),
		.coef_next  (coef_next),
		.coef_raise (coef_raise)
	);

	// Round half up on the magnitude, then drop the coefficient fraction.
	assign prod = PROD_W'(mag) * PROD_W'(coef_next);
	assign prod_rnd = prod + PROD_W'(ROUND_HALF);
	assign step = prod_rnd[PROD_W-1:COEF_FRAC];

	assign filt_ext = {{2{filter_q[W-1]}}, filter_q};
	assign filt_next = neg ? filt_ext - $signed({1'b0, step})
		: filt_ext + $signed({1'b0, step});

	assign filtered = filt_next[W-1:0];
	assign coef_now = coef_next;
	assign filter_state = filter_q;
	assign stat.sign_flip = (neg != last_neg_q);
	assign stat.coef_raise = coef_raise;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= '0;
			last_neg_q <= 1'b0;
			coef_q <= '0;
			count_q <= '0;
		end else if (advance) begin
			filter_q <= filtered;
			last_neg_q <= neg;
			coef_q <= coef_next;
			count_q <= count_next;
		end
	end

endmodule

// ----- sv/adaptive_lowpass_filter_unit.sv -----
// ----------------------------------------------------------------------------
// Adaptive low-pass filter unit
// First-order IIR low-pass whose smoothing coefficient grows while the
// input keeps settling in one direction and drops to zero on a reversal.
// ----------------------------------------------------------------------------
// The unit takes one signed sample per beat and returns one result beat per
// sample, in order: the new filter output and the coefficient that produced
// it. It sustains one sample per clock cycle when the result side is not
// stalled; a sample passes through the input register and then the result
// register before its result beat appears. The one-sample-per-cycle rate
// is set by the filter feedback loop: the subtract against the previous
// output, the 25-by-8 bit multiply and the final add are all combinational,
// so that the next sample sees the updated state. Configuration writes
// take effect at once and must only be made while no sample is in flight.
module adaptive_lowpass_filter_unit import alpf_pkg::*; #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	alpf_in_if.sink              sample_ch,
	alpf_out_if.source           result_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_wdata
);

	localparam int W = SAMPLE_WIDTH;

	cfg_t cfg;

	// Input register stage.
	logic                valid_s1;
	logic signed [W-1:0] sample_s1;

	// Result register.
	logic                res_valid_q;
	logic signed [W-1:0] filtered_q;
	logic [COEF_W-1:0]   coef_q;

	logic                advance;
	logic                take_in;
	logic signed [W-1:0] filtered_next;
	logic [COEF_W-1:0]   coef_next;
	logic signed [W-1:0] filter_state;
	stat_t               stat;

	alpf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The staged sample moves on whenever the result register is empty or
	// its beat is being taken this cycle. The input register then refills in
	// the same cycle, so a result beat taken this cycle does not stop a new
	// sample from entering the input stage. Only a stalled result with the
	// input stage full holds the sample side off.
	assign advance = valid_s1 && (!res_valid_q || result_ch.ready);
	assign sample_ch.ready = !valid_s1 || advance;
	assign take_in = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ch.ready) begin
			valid_s1 <= sample_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			sample_s1 <= sample_ch.sample;
		end
	end

	// All per-sample work happens here, between the two registers.
	alpf_core #(
		.W (W)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.sample       (sample_s1),
		.cfg          (cfg),
		.filtered     (filtered_next),
		.coef_now     (coef_next),
		.filter_state (filter_state),
		.stat         (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			filtered_q <= filtered_next;
			coef_q <= coef_next;
		end
	end

	assign result_ch.valid = res_valid_q;
	assign result_ch.filtered = filtered_q;
	assign result_ch.coef_now = coef_q;

	// A staged sample that cannot move on must stay put.
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(sample_s1)))
		else $error("staged sample lost or changed while stalled");

	// A reversal of the delta sign clears the coefficient to zero.
	a_flip_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && stat.sign_flip) |=> (coef_q == '0))
		else $error("coefficient not cleared after a sign reversal");

	// The new output always lies between the old output and the sample.
	a_output_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=>
		((filtered_q >= $past(filter_state) && filtered_q <= $past(sample_s1)) ||
		 (filtered_q <= $past(filter_state) && filtered_q >= $past(sample_s1))))
		else $error("filter output left the span of old output and sample");

	// A coefficient raise never goes past the configured ceiling.
	a_raise_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && stat.coef_raise) |=> (coef_q <= $past(cfg.max_coef)))
		else $error("coefficient raised above its ceiling");

endmodule

// ----- tb/alpf_result_checker.sv -----
// ----------------------------------------------------------------------------
// Adaptive low-pass filter result checker
// Watches the sample, result and register-write ports of the filter, keeps
// its own copy of the filter state and compares every result beat in order.
// ----------------------------------------------------------------------------
module alpf_result_checker import alpf_pkg::*; #(
	parameter int SW = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	alpf_in_if                   sample_mon,
	alpf_out_if                  result_mon,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_wdata,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct {
		logic signed [SW-1:0] filtered;
		logic [COEF_W-1:0]    coef;
	} filter_result_t;

	// Results predicted for accepted samples, oldest first.
	filter_result_t pending_outputs[$];

	cfg_t                 regs;
	logic signed [SW-1:0] level;
	logic                 falling;
	logic [COEF_W-1:0]    coef;
	logic [COUNT_W-1:0]   settle;

	task automatic report_mismatch(input string what);
		// Keep the log short if the design is badly broken.
		if (mismatches < 40) begin
			$display("%0t: mismatch: %s", $time, what);
		end
		mismatches++;
	endtask

	// Advances the filter by one sample and returns the result it must produce.
	function automatic filter_result_t advance_filter(input logic signed [SW-1:0] x);
		longint         diff;
		longint         mag;
		longint         step;
		longint         next_level;
		int             count;
		logic           neg;
		filter_result_t res;
		diff = longint'(x) - longint'(level);
		neg = diff < 0;
		mag = neg ? -diff : diff;
		if (neg == falling) begin
			if (settle < regs.settle_limit) begin
				count = int'(settle) + ((mag > longint'(regs.big_thr)) ? 10 : 1);
				settle = (count > 255) ? 8'd255 : count[COUNT_W-1:0];
			end else begin
				settle = '0;
				if (int'(coef) + int'(regs.coef_step) < int'(regs.max_coef)) begin
					coef = coef + regs.coef_step;
				end else begin
					coef = regs.max_coef;
				end
			end
		end else begin
			settle = '0;
			coef = '0;
		end
		falling = neg;
		step = (mag * longint'(coef) + ROUND_HALF) >>> COEF_FRAC;
		next_level = neg ? longint'(level) - step : longint'(level) + step;
		level = next_level[SW-1:0];
		res.filtered = level;
		res.coef = coef;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filter_result_t want;
		if (!arst_n) begin
			regs = {MAX_COEF_RST, COEF_STEP_RST, SETTLE_LIMIT_RST, BIG_THR_RST};
			level = '0;
			falling = 1'b0;
			coef = '0;
			settle = '0;
			pending_outputs.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_MAX_COEF: regs.max_coef = cfg_wdata[COEF_W-1:0];
					REG_COEF_STEP: regs.coef_step = cfg_wdata[COEF_W-1:0];
					REG_SETTLE_LIMIT: regs.settle_limit = cfg_wdata[COUNT_W-1:0];
					REG_BIG_THR: regs.big_thr = cfg_wdata;
					default: ;
				endcase
			end
			if (sample_mon.valid && sample_mon.ready) begin
				pending_outputs.push_back(advance_filter(sample_mon.sample));
			end
			if (result_mon.valid && result_mon.ready) begin
				if (pending_outputs.size() == 0) begin
					report_mismatch("result beat with no sample waiting for it");
				end else begin
					want = pending_outputs.pop_front();
					if (result_mon.filtered !== want.filtered) begin
						report_mismatch($sformatf("filtered %0d, expected %0d",
							result_mon.filtered, want.filtered));
					end
					if (result_mon.coef_now !== want.coef) begin
						report_mismatch($sformatf("coef_now %0d, expected %0d",
							result_mon.coef_now, want.coef));
					end
				end
			end
			outstanding = pending_outputs.size();
		end
	end

endmodule

// ----- tb/tb_adaptive_lowpass_filter_unit.sv -----
// ----------------------------------------------------------------------------
// Adaptive low-pass filter unit testbench
// Drives directed and random sample streams through the filter under several
// register settings, with random gaps on the sample side and random stalls on
// the result side; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_adaptive_lowpass_filter_unit;
	import alpf_pkg::*;

	localparam int SW = 24;
	// Sample-to-result delay through the input and result registers when the result side is open.
	localparam int LATENCY = 2;
	// Cycles without any beat on either channel before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Random samples per register setting; six settings give about 1300.
	localparam int PHASE_ITEMS = 215;

	localparam logic signed [SW-1:0] SAMPLE_MAX = 24'sh7FFFFF;
	localparam logic signed [SW-1:0] SAMPLE_MIN = 24'sh800000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [THR_W-1:0]     cfg_wdata = '0;

	alpf_in_if #(.W(SW)) sample_ch ();
	alpf_out_if #(.W(SW)) result_ch ();

	int mismatches;
	int outstanding;
	int idle_cycles = 0;

	// Sender pacing: beats come in bursts; a steady stretch sends with no gaps.
	int burst_left = 0;
	bit steady_sender = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	adaptive_lowpass_filter_unit #(.SAMPLE_WIDTH(SW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	alpf_result_checker #(.SW(SW)) result_check (
		.clk(clk),
		.arst_n(arst_n),
		.sample_mon(sample_ch),
		.result_mon(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// The watchdog only counts cycles in which neither channel moves a beat, so
	// a long run is fine as long as it keeps making progress.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// The result side stalls on a pattern of its own. Each stretch picks a mode:
	// always ready, coin flip, mostly stalled, or a fixed on/off rhythm. The
	// stretch lengths do not line up with the sender's bursts, so stalls land on
	// every phase of the pipeline.
	initial begin
		int mode;
		int span;
		int k;
		result_ch.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 120);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					0: result_ch.ready = 1'b1;
					1: result_ch.ready = 1'($urandom_range(0, 1));
					2: result_ch.ready = ($urandom_range(0, 3) == 0);
					default: result_ch.ready = ((k % 5) < 3);
				endcase
			end
		end
	end

	// Sends one sample beat and returns at the clock edge that accepts it.
	// Valid stays high from one beat to the next within a burst; when a burst
	// runs out, valid drops for a random gap before the next burst starts.
	task automatic send_sample(input logic signed [SW-1:0] value);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = steady_sender ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				sample_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		sample_ch.valid = 1'b1;
		sample_ch.sample = value;
		burst_left--;
		do begin
			@(posedge clk);
		end while (!sample_ch.ready);
	endtask

	// Stops sending and waits until every predicted result has come back, then
	// lets the pipeline settle before returning.
	task automatic drain_results();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [THR_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Writes all four registers with the filter idle. The 8-bit registers get
	// random junk in the upper data bits, which the block must drop.
	task automatic set_filter_regs(input logic [COEF_W-1:0] max_coef,
			input logic [COEF_W-1:0] coef_step, input logic [COUNT_W-1:0] settle_limit,
			input logic [THR_W-1:0] big_thr);
		logic [31:0] junk;
		drain_results();
		junk = $urandom;
		write_reg(REG_MAX_COEF, {junk[15:0], max_coef});
		write_reg(REG_COEF_STEP, {junk[23:8], coef_step});
		write_reg(REG_SETTLE_LIMIT, {junk[31:16], settle_limit});
		write_reg(REG_BIG_THR, big_thr);
	endtask

	// Random samples built from short segments. Most segments hold or ramp the
	// input in one direction, which is what lets the settle count run up and the
	// coefficient climb; the rest are full-scale noise, extremes and square waves
	// that keep flipping the sign of the difference.
	task automatic run_random(input int count);
		int done;
		int kind;
		int len;
		int amp;
		int slope;
		int k;
		logic signed [SW-1:0] target;
		logic signed [SW-1:0] value;
		done = 0;
		while (done < count) begin
			kind = $urandom_range(0, 9);
			len = $urandom_range(4, 60);
			steady_sender = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1)) begin
				target = SW'($urandom);
			end else begin
				target = SW'(int'($urandom_range(0, 4000)) - 2000);
			end
			case ($urandom_range(0, 2))
				0: amp = 0;
				1: amp = 3;
				default: amp = 300;
			endcase
			slope = int'($urandom_range(0, 2000)) - 1000;
			for (k = 0; k < len && done < count; k++) begin
				if (kind <= 4) begin
					value = SW'(int'(target) + int'($urandom_range(0, 2 * amp)) - amp);
				end else if (kind <= 6) begin
					value = SW'(int'(target) + k * slope);
				end else if (kind == 7) begin
					value = SW'($urandom);
				end else if (kind == 8) begin
					case ($urandom_range(0, 4))
						0: value = SAMPLE_MAX;
						1: value = SAMPLE_MIN;
						2: value = '0;
						3: value = '1;
						default: value = SW'(1);
					endcase
				end else begin
					value = (k % 2) ? target : -target;
				end
				send_sample(value);
				done++;
			end
		end
	endtask

	initial begin
		int k;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset register values: zero difference against
		// the cleared output, both full-scale extremes, values around zero and
		// alternating bit patterns.
		steady_sender = 1'b0;
		send_sample('0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample('1);
		send_sample('0);
		send_sample(SW'(1));
		send_sample(24'sh555555);
		send_sample(24'shAAAAAA);

		// Zero limit with the largest step and ceiling: every same-sign sample
		// raises the coefficient, and the raise is capped at once. Full-scale
		// swings with the coefficient at 255 check that the output stays between
		// the old output and the sample.
		set_filter_regs(8'd255, 8'd255, 8'd0, 24'd0);
		repeat (3) send_sample(SAMPLE_MIN);
		for (k = 0; k < 4; k++) begin
			send_sample(SAMPLE_MAX);
		end

		// Ceiling below both the step and the present coefficient: the
		// coefficient must fall to the new ceiling on the next raise.
		set_filter_regs(8'd3, 8'd255, 8'd0, 24'hFFFFFF);
		repeat (3) send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);

		// Random part. The first setting lets the settle count saturate: the
		// limit sits above anything that ten-step growth can land on.
		set_filter_regs(8'd255, 8'd255, 8'd255, 24'd0);
		run_random(PHASE_ITEMS);

		set_filter_regs(8'd0, 8'd0, 8'd245, 24'hFFFFFF);
		run_random(PHASE_ITEMS);

		// Mid-phase, the sender holds off until every result is back.
		set_filter_regs(COEF_W'($urandom_range(0, 255)), COEF_W'($urandom_range(0, 40)),
			COUNT_W'($urandom_range(0, 40)), THR_W'($urandom_range(0, 500)));
		run_random(PHASE_ITEMS / 2);
		drain_results();
		run_random(PHASE_ITEMS - PHASE_ITEMS / 2);

		set_filter_regs(COEF_W'($urandom_range(0, 255)), COEF_W'($urandom_range(0, 255)),
			COUNT_W'($urandom_range(0, 12)), THR_W'($urandom));
		run_random(PHASE_ITEMS);

		set_filter_regs(COEF_W'($urandom_range(100, 255)), COEF_W'($urandom_range(1, 20)),
			COUNT_W'($urandom_range(0, 245)), THR_W'($urandom_range(0, 5000)));
		run_random(PHASE_ITEMS);

		// Back to the reset values, so the default behavior is also seen under
		// random traffic.
		set_filter_regs(MAX_COEF_RST, COEF_STEP_RST, SETTLE_LIMIT_RST, BIG_THR_RST);
		run_random(PHASE_ITEMS);

		drain_results();
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
